/* hw/rtl/sict_pkg.sv */
// Shared types, constants and band tables for the spray icing class table.
// No dependencies; imported by every module of the block.
package sict_pkg;

    // Field widths
    localparam int AIR_W    = 14;
    localparam int SST_W    = 13;
    localparam int WIND_W   = 15;
    localparam int SAL_W    = 13;
    localparam int ICE_W    = 10;
    localparam int CLASS_W  = 3;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ICE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ASSUME_ALL_DEFINED = 1'd0,
        REG_ICE_FRACTION_LIMIT = 1'd1
    } cfg_reg_t;

    localparam logic [ICE_W-1:0] ICE_LIMIT_RESET = 10'd400;

    // Field point counters saturate here
    localparam int MAX_POINTS = 1048576;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Squared wind in (cm/s)^2; square of a WIND_W signed value
    localparam int SQ_W = 2 * WIND_W - 1;
    localparam logic [SQ_W:0] SQ_CALM   = 30'd1166400;  // 10.8 m/s
    localparam logic [SQ_W:0] SQ_BAND_1 = 30'd2958400;  // 17.2 m/s
    localparam logic [SQ_W:0] SQ_BAND_2 = 30'd4326400;  // 20.8 m/s
    localparam logic [SQ_W:0] SQ_BAND_3 = 30'd8122500;  // 28.5 m/s

    // Brine freezing point test, scaled by 1e7 in 0.01 units
    localparam int TF_W = 40;
    localparam logic signed [TF_W-1:0] TF_SST_SCALE = 40'sd10000000;
    localparam logic signed [TF_W-1:0] TF_C0        = -40'sd2000000;
    localparam logic signed [TF_W-1:0] TF_C1        = 40'sd524000;
    localparam logic signed [TF_W-1:0] TF_C2        = 40'sd6;
    localparam int SAL_SQ_W = 2 * SAL_W;

    // Air temperature lines: 1000*air > k*sst + c
    localparam int LINE_W    = 28;
    localparam int NUM_BANDS = 4;
    localparam int NUM_LINES = 3;
    localparam logic signed [LINE_W-1:0] AIR_SCALE = 28'sd1000;
    localparam logic signed [AIR_W-1:0]  AIR_WARM_LIMIT = -14'sd200;

    typedef logic signed [LINE_W-1:0] line_tab_t [NUM_BANDS][NUM_LINES];

    localparam line_tab_t LINE_K = '{
        '{-28'sd1150, -28'sd1500,  28'sd0},
        '{-28'sd600,  -28'sd1050, -28'sd1750},
        '{-28'sd300,  -28'sd660,  -28'sd1325},
        '{-28'sd140,  -28'sd300,  -28'sd1160}
    };

    localparam line_tab_t LINE_C = '{
        '{-28'sd430000, -28'sd1000000,  28'sd0},
        '{-28'sd320000, -28'sd560000,  -28'sd1250000},
        '{-28'sd260000, -28'sd332000,  -28'sd765100},
        '{-28'sd228000, -28'sd260000,  -28'sd522000}
    };

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NONE     = 3'd0,
        CLASS_LIGHT    = 3'd1,
        CLASS_MODERATE = 3'd2,
        CLASS_HEAVY    = 3'd3,
        CLASS_SEVERE   = 3'd4
    } icing_class_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NOT_LAST     = 2'd0,
        STATUS_ALL_DEFINED  = 2'd1,
        STATUS_SOME_DEFINED = 2'd2,
        STATUS_NONE_DEFINED = 2'd3
    } field_status_t;

    typedef struct packed {
        logic signed [AIR_W-1:0]  air_temp;
        logic signed [SST_W-1:0]  sea_temp;
        logic signed [WIND_W-1:0] wind_east;
        logic signed [WIND_W-1:0] wind_north;
        logic [SAL_W-1:0]         salinity;
        logic [ICE_W-1:0]         ice_fraction;
        logic                     values_defined;
        logic                     last_point;
    } in_item_t;

    typedef struct packed {
        logic                                    usable;
        logic                                    last_point;
        logic [SQ_W-1:0]                         sq_east;
        logic [SQ_W-1:0]                         sq_north;
        logic [SAL_SQ_W-1:0]                     sal_sq;
        logic signed [TF_W-1:0]                  tf_lhs;
        logic signed [TF_W-1:0]                  tf_rhs;
        logic                                    air_warm;
        logic [NUM_BANDS-1:0][NUM_LINES-1:0]     line_above;
    } prep_t;

endpackage

/* hw/rtl/sict_prep.sv */
// Feature stage: squares, freezing point terms and line compares per point.
// Depends on sict_pkg.
module sict_prep
    import sict_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic             in_valid,
    input  in_item_t         in_item,
    input  logic             assume_all_defined,
    input  logic [ICE_W-1:0] ice_fraction_limit,
    output logic             prep_valid,
    output prep_t            prep
);

    logic                        valid_reg;
    prep_t                       prep_reg;
    prep_t                       prep_next;
    logic signed [2*WIND_W-1:0]  prod_east;
    logic signed [2*WIND_W-1:0]  prod_north;
    logic signed [TF_W-1:0]      sst_tf;
    logic signed [TF_W-1:0]      sal_tf;
    logic signed [LINE_W-1:0]    air_line;
    logic signed [LINE_W-1:0]    sst_line;
    logic signed [LINE_W-1:0]    air_scaled;

    always_comb begin
        prod_east  = in_item.wind_east * in_item.wind_east;
        prod_north = in_item.wind_north * in_item.wind_north;
        sst_tf     = TF_W'(in_item.sea_temp);
        sal_tf     = signed'(TF_W'(in_item.salinity));
        air_line   = LINE_W'(in_item.air_temp);
        sst_line   = LINE_W'(in_item.sea_temp);
        air_scaled = air_line * AIR_SCALE;

        prep_next.usable     = (in_item.values_defined | assume_all_defined)
                             & (in_item.ice_fraction < ice_fraction_limit);
        prep_next.last_point = in_item.last_point;
        prep_next.sq_east    = prod_east[SQ_W-1:0];
        prep_next.sq_north   = prod_north[SQ_W-1:0];
        prep_next.sal_sq     = in_item.salinity * in_item.salinity;
        prep_next.tf_lhs     = sst_tf * TF_SST_SCALE;
        prep_next.tf_rhs     = TF_C0 - TF_C1 * sal_tf;
        prep_next.air_warm   = in_item.air_temp > AIR_WARM_LIMIT;

        // every band's lines in parallel; the band is picked downstream
        for (int b = 0; b < NUM_BANDS; b++) begin
            for (int l = 0; l < NUM_LINES; l++) begin
                prep_next.line_above[b][l] =
                    air_scaled > (sst_line * LINE_K[b][l] + LINE_C[b][l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prep_reg <= prep_next;
        end
    end

    assign prep_valid = valid_reg;
    assign prep       = prep_reg;

endmodule

/* hw/rtl/sict_resolve.sv */
// Result stage: freezing check, wind band, class pick and field counters.
// Depends on sict_pkg.
module sict_resolve
    import sict_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic                prep_valid,
    input  prep_t               prep,
    output logic                out_valid,
    output logic [CLASS_W-1:0]  icing_class,
    output logic                point_undefined,
    output logic [STATUS_W-1:0] field_status
);

    logic                valid_reg;
    icing_class_t        class_reg;
    icing_class_t        class_next;
    logic                undef_reg;
    logic                undef_next;
    field_status_t       status_reg;
    field_status_t       status_next;
    logic [CNT_W-1:0]    points_seen_reg;
    logic [CNT_W-1:0]    points_seen_next;
    logic [CNT_W-1:0]    undefined_points_reg;
    logic [CNT_W-1:0]    undefined_points_next;
    logic [CNT_W-1:0]    seen_count;
    logic [CNT_W-1:0]    undef_count;
    logic signed [TF_W-1:0] sal_term;
    logic                sea_frozen;
    logic [SQ_W:0]       wind_sq;
    logic [1:0]          band;
    logic [NUM_LINES-1:0] above;

    always_comb begin
        sal_term   = signed'(TF_W'(prep.sal_sq)) * TF_C2;
        sea_frozen = (prep.tf_lhs + sal_term) < prep.tf_rhs;
        undef_next = !prep.usable || sea_frozen;

        wind_sq = {1'b0, prep.sq_east} + {1'b0, prep.sq_north};
        if (wind_sq < SQ_BAND_1) begin
            band = 2'd0;
        end else if (wind_sq < SQ_BAND_2) begin
            band = 2'd1;
        end else if (wind_sq < SQ_BAND_3) begin
            band = 2'd2;
        end else begin
            band = 2'd3;
        end
        above = prep.line_above[band];

        class_next = CLASS_NONE;
        if (!undef_next && wind_sq >= SQ_CALM && !prep.air_warm) begin
            if (above[0]) begin
                class_next = CLASS_LIGHT;
            end else if (above[1]) begin
                class_next = CLASS_MODERATE;
            end else if (band == 2'd0 || !above[2]) begin
                class_next = CLASS_HEAVY;
            end else begin
                class_next = CLASS_SEVERE;
            end
        end

        // saturating counts, this point included
        seen_count = points_seen_reg;
        if (points_seen_reg < CNT_W'(MAX_POINTS)) begin
            seen_count = points_seen_reg + 1'b1;
        end
        undef_count = undefined_points_reg;
        if (undef_next && undefined_points_reg < CNT_W'(MAX_POINTS)) begin
            undef_count = undefined_points_reg + 1'b1;
        end

        status_next           = STATUS_NOT_LAST;
        points_seen_next      = seen_count;
        undefined_points_next = undef_count;
        if (prep.last_point) begin
            if (undef_count == '0) begin
                status_next = STATUS_ALL_DEFINED;
            end else if (undef_count >= seen_count) begin
                status_next = STATUS_NONE_DEFINED;
            end else begin
                status_next = STATUS_SOME_DEFINED;
            end
            points_seen_next      = '0;
            undefined_points_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg            <= 1'b0;
            points_seen_reg      <= '0;
            undefined_points_reg <= '0;
        end else if (load) begin
            valid_reg <= prep_valid;
            if (prep_valid) begin
                points_seen_reg      <= points_seen_next;
                undefined_points_reg <= undefined_points_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && prep_valid) begin
            class_reg  <= class_next;
            undef_reg  <= undef_next;
            status_reg <= status_next;
        end
    end

    assign out_valid       = valid_reg;
    assign icing_class     = class_reg;
    assign point_undefined = undef_reg;
    assign field_status    = status_reg;

endmodule

/* hw/rtl/spray_icing_class_table.sv */
// Top level of the spray icing class table: handshake, input register, config.
// Depends on sict_pkg, sict_prep and sict_resolve.
//
// Classifies one ocean grid point per transfer into a vessel spray icing class
// (none, 0.8333, 2.0833, 4.375 or 6.25 cm/h) and flags points that are missing,
// under sea ice at or above the configured limit, or colder than the brine
// freezing point. The pipeline has three register stages (input register,
// feature register, result register), and one point per cycle is
// sustained while m_ready stays high; the feature and result stages are
// each a single pass of squares, constant products and compares.
// Every stage advances whenever the stage after it is empty or moving, so
// bubbles collapse and a waiting result does not block new input while a
// stage is free. On the transfer flagged last_point, m_field_status reports
// whether all, some or none of the field's points were defined (counts include
// that point, saturating at MAX_POINTS), then the counters clear for the next
// field; on other points it is zero. Write configuration only while no
// transfer is in flight; register 0 forces every point's values to count as
// defined, register 1 holds the ice fraction limit in per mille (reset 400).
module spray_icing_class_table
    import sict_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wr_data,
    // grid point input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [AIR_W-1:0]  s_air_temp,
    input  logic signed [SST_W-1:0]  s_sea_temp,
    input  logic signed [WIND_W-1:0] s_wind_east,
    input  logic signed [WIND_W-1:0] s_wind_north,
    input  logic [SAL_W-1:0]         s_salinity,
    input  logic [ICE_W-1:0]         s_ice_fraction,
    input  logic                     s_values_defined,
    input  logic                     s_last_point,
    // classification result
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CLASS_W-1:0]       m_icing_class,
    output logic                     m_point_undefined,
    output logic [STATUS_W-1:0]      m_field_status
);

    logic             assume_all_defined_reg;
    logic [ICE_W-1:0] ice_fraction_limit_reg;
    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             prep_valid;
    prep_t            prep;
    logic             load_out;
    logic             load_prep;
    logic             load_in;

    // Stage enables: a stage may load when it is empty or its contents move on.
    assign load_out  = !m_valid || m_ready;
    assign load_prep = !prep_valid || load_out;
    assign load_in   = !in_valid_reg || load_prep;
    assign s_ready   = load_in;

    // Configuration registers; writes land immediately.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            assume_all_defined_reg <= 1'b0;
            ice_fraction_limit_reg <= ICE_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_ASSUME_ALL_DEFINED: assume_all_defined_reg <= cfg_wr_data[0];
                REG_ICE_FRACTION_LIMIT: ice_fraction_limit_reg <= cfg_wr_data[ICE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the point until the feature stage takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load_in) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in && s_valid) begin
            in_item_reg.air_temp       <= s_air_temp;
            in_item_reg.sea_temp       <= s_sea_temp;
            in_item_reg.wind_east      <= s_wind_east;
            in_item_reg.wind_north     <= s_wind_north;
            in_item_reg.salinity       <= s_salinity;
            in_item_reg.ice_fraction   <= s_ice_fraction;
            in_item_reg.values_defined <= s_values_defined;
            in_item_reg.last_point     <= s_last_point;
        end
    end

    sict_prep u_prep (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .load               (load_prep),
        .in_valid           (in_valid_reg),
        .in_item            (in_item_reg),
        .assume_all_defined (assume_all_defined_reg),
        .ice_fraction_limit (ice_fraction_limit_reg),
        .prep_valid         (prep_valid),
        .prep               (prep)
    );

    sict_resolve u_resolve (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load_out),
        .prep_valid      (prep_valid),
        .prep            (prep),
        .out_valid       (m_valid),
        .icing_class     (m_icing_class),
        .point_undefined (m_point_undefined),
        .field_status    (m_field_status)
    );

endmodule
